// ===== rtl/tws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg
// Shared constants, codes and types of the timing wheel scheduler.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int NUM_SLOTS    = 64;
  localparam int SLOT_DEPTH   = 16;
  localparam int TASK_ID_BITS = 16;

  localparam int SLOT_W       = $clog2(NUM_SLOTS);
  localparam int IDX_W        = $clog2(SLOT_DEPTH);
  localparam int FILL_W       = $clog2(SLOT_DEPTH + 1);
  localparam int ENTRY_ADDR_W = SLOT_W + IDX_W;
  localparam int SUM_W        = SLOT_W + 1;

  // fixed widths of the port fields
  localparam int SIU_W    = 7;
  localparam int DELAY_W  = 8;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 2;

  localparam logic [SIU_W-1:0] SIU_RESET = SIU_W'(60);

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_FIRED  = 1'b1
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_TOO_FAR = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic [TASK_ID_BITS-1:0] id;
    logic                    rep;
    logic [SLOT_W-1:0]       delay;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/tws_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_req_if
// Request channel: add or tick beats into the scheduler.
// ----------------------------------------------------------------------------
interface tws_req_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [tws_pkg::ID_W-1:0]     task_id;
  logic [tws_pkg::DELAY_W-1:0]  delay;
  logic                         repeat_req;

  modport source (output valid, operation, task_id, delay, repeat_req, input ready);
  modport sink   (input valid, operation, task_id, delay, repeat_req, output ready);
endinterface

// ===== rtl/tws_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_rsp_if
// Response channel: add status and fired task beats.
// ----------------------------------------------------------------------------
interface tws_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [tws_pkg::STATUS_W-1:0]  status;
  logic [tws_pkg::ID_W-1:0]      task_id_res;
  logic                          last;

  modport source (output valid, kind, status, task_id_res, last, input ready);
  modport sink   (input valid, kind, status, task_id_res, last, output ready);
endinterface

// ===== rtl/tws_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_cfg_if
// Configuration write channel for the slots_in_use register.
// ----------------------------------------------------------------------------
interface tws_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tws_pkg::SIU_W-1:0]  slots_in_use;

  modport source (output valid, slots_in_use, input ready);
  modport sink   (input valid, slots_in_use, output ready);
endinterface

// ===== rtl/tws_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/timing_wheel_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timing_wheel_scheduler_core
// Single-level timing wheel: adds place task ids into slots, ticks drain them.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one beat per command: add (task_id, delay, repeat_req) or tick.
//   rsp  - an add gives one status beat with last set; a tick gives one beat
//          per task queued in the new slot, oldest first, last on the final
//          one, and nothing for an empty slot.
//   cfg  - writes slots_in_use (0 taken as 1, above 64 taken as 64); write it
//          only while the block is idle.
// Flow: one command at a time, req.ready is low until it is done.
//   add : mod loop (one subtraction of slots_in_use per step in the shared
//         loop, up to 63 after slots_in_use shrinks), fill, then the status
//         beat is loaded; a too-far add skips the loop and the fill.
//   tick: fill read and check of the new slot, then per fired task an entry
//         RAM read and an output load, plus the mod loop and a fill for
//         each repeating task that is put back.
// Stall: results sit in an output register; the sequencer waits while that
//   register is full and rsp.ready is low, nothing is dropped.
// Reset: pointer to 0, slots_in_use to 60, every slot reads empty at once
//   through per-slot valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module timing_wheel_scheduler_core (
  input logic           clk,
  input logic           rst,
  tws_req_if.sink       req,
  tws_rsp_if.source     rsp,
  tws_cfg_if.sink       cfg
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_MOD      = 8'b0000_0010,
    S_FILL     = 8'b0000_0100,
    S_ADD_OUT  = 8'b0000_1000,
    S_TICK_RD  = 8'b0001_0000,
    S_TICK_CHK = 8'b0010_0000,
    S_ENT_RD   = 8'b0100_0000,
    S_ENT_OUT  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [tws_pkg::SIU_W-1:0]        siu;
  logic [tws_pkg::SLOT_W-1:0]       ptr;
  logic [tws_pkg::SUM_W-1:0]        rem;
  logic                             requeue;
  logic [tws_pkg::TASK_ID_BITS-1:0] cur_id;
  logic [tws_pkg::SLOT_W-1:0]       cur_delay;
  logic                             cur_rep;
  tws_pkg::status_t                 add_status;
  logic [tws_pkg::IDX_W-1:0]        idx;
  logic [tws_pkg::IDX_W-1:0]        idx_last;
  logic [tws_pkg::NUM_SLOTS-1:0]    fill_valid;

  // output register
  logic                             out_valid;
  tws_pkg::kind_t                   out_kind;
  tws_pkg::status_t                 out_status;
  logic [tws_pkg::ID_W-1:0]         out_id;
  logic                             out_last;

  // ram ports
  logic                             fill_rd_en;
  logic [tws_pkg::SLOT_W-1:0]       fill_rd_addr;
  logic [tws_pkg::FILL_W-1:0]       fill_q;
  logic                             fill_wr_en;
  logic [tws_pkg::FILL_W-1:0]       fill_wr_data;
  logic                             ent_wr_en;
  logic [tws_pkg::ENTRY_ADDR_W-1:0] ent_wr_addr;
  tws_pkg::entry_t                  ent_wr_data;
  logic                             ent_rd_en;
  tws_pkg::entry_t                  ent_q;

  logic                             req_fire;
  logic                             cfg_fire;
  logic                             out_free;
  logic                             mod_more;
  logic [tws_pkg::SLOT_W-1:0]       cur_slot;
  logic [tws_pkg::FILL_W-1:0]       fill_cur;
  logic                             slot_full;
  logic [tws_pkg::SIU_W-1:0]        ptr_inc;
  logic [tws_pkg::SLOT_W-1:0]       ptr_adv;
  logic [tws_pkg::SIU_W-1:0]        cfg_clamped;
  logic                             ent_last;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid       = out_valid;
  assign rsp.kind        = out_kind;
  assign rsp.status      = out_status;
  assign rsp.task_id_res = out_id;
  assign rsp.last        = out_last;

  // shared compare of the mod loop
  assign mod_more = (rem >= tws_pkg::SUM_W'(siu));

  assign cur_slot  = (state == S_TICK_CHK) ? ptr : rem[tws_pkg::SLOT_W-1:0];
  assign fill_cur  = fill_valid[cur_slot] ? fill_q : '0;
  assign slot_full = (fill_cur >= tws_pkg::FILL_W'(tws_pkg::SLOT_DEPTH));
  assign ent_last  = (idx == idx_last);

  assign ptr_inc = tws_pkg::SIU_W'(ptr) + tws_pkg::SIU_W'(1);
  assign ptr_adv = (ptr_inc >= siu) ? '0 : ptr_inc[tws_pkg::SLOT_W-1:0];

  always_comb begin
    cfg_clamped = cfg.slots_in_use;
    if (cfg.slots_in_use == '0) begin
      cfg_clamped = tws_pkg::SIU_W'(1);
    end else if (cfg.slots_in_use > tws_pkg::SIU_W'(tws_pkg::NUM_SLOTS)) begin
      cfg_clamped = tws_pkg::SIU_W'(tws_pkg::NUM_SLOTS);
    end
  end

  always_comb begin
    fill_rd_en   = ((state == S_MOD) && !mod_more) || (state == S_TICK_RD);
    fill_rd_addr = (state == S_TICK_RD) ? ptr : rem[tws_pkg::SLOT_W-1:0];
    fill_wr_en   = (state == S_FILL) && !slot_full;
    fill_wr_data = fill_cur + tws_pkg::FILL_W'(1);
    ent_wr_en    = fill_wr_en;
    ent_wr_addr  = {rem[tws_pkg::SLOT_W-1:0], fill_cur[tws_pkg::IDX_W-1:0]};
    ent_wr_data  = '{id: cur_id, rep: cur_rep, delay: cur_delay};
    ent_rd_en    = (state == S_ENT_RD);
  end

  tws_ram #(
    .WIDTH (tws_pkg::FILL_W),
    .DEPTH (tws_pkg::NUM_SLOTS)
  ) u_fill_ram (
    .clk     (clk),
    .wr_en   (fill_wr_en),
    .wr_addr (rem[tws_pkg::SLOT_W-1:0]),
    .wr_data (fill_wr_data),
    .rd_en   (fill_rd_en),
    .rd_addr (fill_rd_addr),
    .rd_data (fill_q)
  );

  tws_ram #(
    .WIDTH (tws_pkg::ENTRY_W),
    .DEPTH (tws_pkg::NUM_SLOTS * tws_pkg::SLOT_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ent_wr_en),
    .wr_addr (ent_wr_addr),
    .wr_data (ent_wr_data),
    .rd_en   (ent_rd_en),
    .rd_addr ({ptr, idx}),
    .rd_data (ent_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      siu        <= tws_pkg::SIU_RESET;
      ptr        <= '0;
      fill_valid <= '0;
      out_valid  <= 1'b0;
      requeue    <= 1'b0;
    end else begin
      if (cfg_fire) begin
        siu <= cfg_clamped;
      end
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (fill_wr_en) begin
        fill_valid[rem[tws_pkg::SLOT_W-1:0]] <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (req.operation == tws_pkg::OP_ADD) begin
              cur_id    <= req.task_id[tws_pkg::TASK_ID_BITS-1:0];
              cur_delay <= req.delay[tws_pkg::SLOT_W-1:0];
              cur_rep   <= req.repeat_req;
              requeue   <= 1'b0;
              rem       <= tws_pkg::SUM_W'(ptr)
                         + tws_pkg::SUM_W'(req.delay[tws_pkg::SLOT_W-1:0]);
              if (req.delay >= tws_pkg::DELAY_W'(siu)) begin
                add_status <= tws_pkg::ST_TOO_FAR;
                state      <= S_ADD_OUT;
              end else begin
                state <= S_MOD;
              end
            end else begin
              ptr   <= ptr_adv;
              state <= S_TICK_RD;
            end
          end
        end

        S_MOD: begin
          if (mod_more) begin
            rem <= rem - tws_pkg::SUM_W'(siu);
          end else begin
            state <= S_FILL;
          end
        end

        S_FILL: begin
          add_status <= slot_full ? tws_pkg::ST_FULL : tws_pkg::ST_OK;
          if (!requeue) begin
            state <= S_ADD_OUT;
          end else if (ent_last) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx + tws_pkg::IDX_W'(1);
            state <= S_ENT_RD;
          end
        end

        S_ADD_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_kind   <= tws_pkg::KIND_STATUS;
            out_status <= add_status;
            out_id     <= tws_pkg::ID_W'(cur_id);
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end

        S_TICK_RD: begin
          state <= S_TICK_CHK;
        end

        S_TICK_CHK: begin
          // the slot reads empty from here on, requeues refill it from entry 0
          fill_valid[ptr] <= 1'b0;
          idx             <= '0;
          idx_last        <= tws_pkg::IDX_W'(fill_cur - tws_pkg::FILL_W'(1));
          state           <= (fill_cur == '0) ? S_IDLE : S_ENT_RD;
        end

        S_ENT_RD: begin
          state <= S_ENT_OUT;
        end

        S_ENT_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_kind   <= tws_pkg::KIND_FIRED;
            out_status <= tws_pkg::ST_OK;
            out_id     <= tws_pkg::ID_W'(ent_q.id);
            out_last   <= ent_last;
            cur_id     <= ent_q.id;
            cur_delay  <= ent_q.delay;
            cur_rep    <= 1'b1;
            requeue    <= 1'b1;
            rem        <= tws_pkg::SUM_W'(ptr) + tws_pkg::SUM_W'(ent_q.delay);
            if (ent_q.rep && (tws_pkg::SIU_W'(ent_q.delay) < siu)) begin
              state <= S_MOD;
            end else if (ent_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + tws_pkg::IDX_W'(1);
              state <= S_ENT_RD;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
